/* design/pidc_pkg.sv */
// ----------------------------------------------------------------------------
// pidc_pkg: shared types and constants of the clamped PID controller
// Fixed-point widths, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

    // Q16.16 data path
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;

    // error = target - sample, diff = error - last error
    localparam int ERR_W     = DATA_W + 1;
    localparam int DIFF_W    = DATA_W + 2;

    // divider: |diff| << FRAC_W over step_time
    localparam int DIV_NUM_W = DIFF_W - 1 + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
    localparam int DER_W     = DIV_NUM_W + 1;

    // shared multiplier: signed A by signed B, B taken in two chunks
    localparam int MUL_A_W   = ERR_W;
    localparam int MUL_B_W   = DER_W;
    localparam int MUL_CH_W  = 32;
    localparam int MUL_HI_W  = MUL_B_W - MUL_CH_W;
    localparam int PROD_W    = DATA_W + MUL_CH_W;
    localparam int ACC_W     = DATA_W + MUL_B_W;
    localparam int Q_W       = ACC_W - FRAC_W;
    localparam int TERM_W    = 62;            // terms saturate to +-(2^61 - 1)
    localparam int SUM_W     = 64;

    // stream packing
    localparam int TDATA_W   = ((3 * DATA_W + 7) / 8) * 8;
    localparam int OUT_W     = ((DATA_W + 7) / 8) * 8;

    // configuration registers
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOWER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_UPPER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LOWER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_UPPER = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_INT_MUL,
        S_INT_WAIT,
        S_INT_CLAMP,
        S_P_MUL,
        S_P_WAIT,
        S_I_MUL,
        S_I_WAIT,
        S_D_MUL,
        S_D_WAIT,
        S_OUT_CLAMP
    } t_state;

endpackage

`default_nettype wire

/* design/pid_controller_clamped.sv */
// ----------------------------------------------------------------------------
// pid_controller_clamped: PID controller with integral clamp anti-windup
// Signed Q16.16 control update per request, sequenced over one shared
// multiplier and a bit-serial divider for the derivative.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                  Payload (LSB first)
//  --------  ---  -------------------------  ----------------------------------
//  s_axis    in   s_axis_tvalid/tready       tdata: target, sample, step_time
//                                            tuser: clear_first
//  m_axis    out  m_axis_tvalid/tready       tdata: drive
//  cfg       in   i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
//  When step_time is nonzero, the divider (one quotient bit per cycle,
//  49 bits) runs alongside the integral and P/I multiplies and sets the
//  pace.
//  Reset: synchronous, active low; gains clear, limits go to full range,
//  integral and last error clear.
//  Stalls: one request at a time; the finished drive sits in an output
//  register so the next request is taken while m_axis is held off.
//  The config port is always ready; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_clamped (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // control update requests
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [pidc_pkg::TDATA_W-1:0]       s_axis_tdata,  // target, sample, step_time
    input  wire logic                               s_axis_tuser,  // clear_first
    // control output
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [pidc_pkg::OUT_W-1:0]              m_axis_tdata,  // drive
    // register writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [pidc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pidc_pkg::DATA_W-1:0]        i_cfg_data
);

    localparam int DW = pidc_pkg::DATA_W;

    localparam logic signed [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};

    // upper bound wins first
    function automatic logic signed [DW-1:0] clamp_sum(
        input logic signed [pidc_pkg::SUM_W-1:0] v,
        input logic signed [DW-1:0]              lo,
        input logic signed [DW-1:0]              hi
    );
        logic signed [DW-1:0] res;
        if (v > pidc_pkg::SUM_W'(hi)) begin
            res = hi;
        end else if (v < pidc_pkg::SUM_W'(lo)) begin
            res = lo;
        end else begin
            res = DW'(v);
        end
        return res;
    endfunction

    // configuration
    logic signed [DW-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic signed [DW-1:0] r_out_lo, r_out_hi, r_int_lo, r_int_hi;

    // controller state
    logic signed [DW-1:0]                 r_integ;
    logic signed [pidc_pkg::ERR_W-1:0]    r_last_err;

    // per-request working registers
    pidc_pkg::t_state                     r_state, n_state;
    logic signed [DW-1:0]                 r_target, r_sample;
    logic [DW-1:0]                        r_dt;
    logic signed [pidc_pkg::ERR_W-1:0]    r_err;
    logic signed [pidc_pkg::DIFF_W-1:0]   r_diff;
    logic signed [pidc_pkg::DER_W-1:0]    r_deriv;
    logic                                 r_div_fin;
    logic signed [pidc_pkg::SUM_W-1:0]    r_sum;
    logic                                 r_out_valid;
    logic [DW-1:0]                        r_out_data;

    // sequencer outputs
    logic                                 w_mul_start;
    logic signed [pidc_pkg::MUL_A_W-1:0]  w_mul_a;
    logic signed [pidc_pkg::MUL_B_W-1:0]  w_mul_b;
    logic                                 w_div_start;
    logic                                 w_accept;
    logic                                 w_out_free;

    // unit results
    logic                                 w_mul_done;
    logic signed [pidc_pkg::TERM_W-1:0]   w_term;
    logic                                 w_div_done;
    logic [pidc_pkg::DIV_NUM_W-1:0]       w_quo;
    logic [pidc_pkg::DIFF_W-2:0]          w_diff_mag;
    logic signed [pidc_pkg::DIFF_W-1:0]   w_diff_abs;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_diff_abs = r_diff[pidc_pkg::DIFF_W-1] ? -r_diff : r_diff;
    assign w_diff_mag = w_diff_abs[pidc_pkg::DIFF_W-2:0];

    // ------------------------------------------------------------------
    // register file
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_out_lo <= MOST_NEG;
            r_out_hi <= MOST_POS;
            r_int_lo <= MOST_NEG;
            r_int_hi <= MOST_POS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pidc_pkg::CFG_GAIN_PROP:   r_gain_p <= i_cfg_data;
                pidc_pkg::CFG_GAIN_INTEG:  r_gain_i <= i_cfg_data;
                pidc_pkg::CFG_GAIN_DERIV:  r_gain_d <= i_cfg_data;
                pidc_pkg::CFG_OUT_LOWER:   r_out_lo <= i_cfg_data;
                pidc_pkg::CFG_OUT_UPPER:   r_out_hi <= i_cfg_data;
                pidc_pkg::CFG_INTEG_LOWER: r_int_lo <= i_cfg_data;
                pidc_pkg::CFG_INTEG_UPPER: r_int_hi <= i_cfg_data;
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pidc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_mul_start   = 1'b0;
        w_mul_a       = r_err;
        w_mul_b       = pidc_pkg::MUL_B_W'({1'b0, r_dt});
        w_div_start   = 1'b0;
        case (r_state)
            pidc_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = pidc_pkg::S_ERR;
                end
            end
            pidc_pkg::S_ERR: begin
                n_state = pidc_pkg::S_INT_MUL;
            end
            pidc_pkg::S_INT_MUL: begin
                // err * dt on the multiplier, derivative divide in parallel
                w_mul_start = 1'b1;
                w_div_start = (r_dt != '0);
                n_state     = pidc_pkg::S_INT_WAIT;
            end
            pidc_pkg::S_INT_WAIT: begin
                if (w_mul_done) begin
                    n_state = pidc_pkg::S_INT_CLAMP;
                end
            end
            pidc_pkg::S_INT_CLAMP: begin
                n_state = pidc_pkg::S_P_MUL;
            end
            pidc_pkg::S_P_MUL: begin
                w_mul_start = 1'b1;
                w_mul_a     = pidc_pkg::MUL_A_W'(r_gain_p);
                w_mul_b     = pidc_pkg::MUL_B_W'(r_err);
                n_state     = pidc_pkg::S_P_WAIT;
            end
            pidc_pkg::S_P_WAIT: begin
                if (w_mul_done) begin
                    n_state = pidc_pkg::S_I_MUL;
                end
            end
            pidc_pkg::S_I_MUL: begin
                w_mul_start = 1'b1;
                w_mul_a     = pidc_pkg::MUL_A_W'(r_gain_i);
                w_mul_b     = pidc_pkg::MUL_B_W'(r_integ);
                n_state     = pidc_pkg::S_I_WAIT;
            end
            pidc_pkg::S_I_WAIT: begin
                if (w_mul_done) begin
                    n_state = pidc_pkg::S_D_MUL;
                end
            end
            pidc_pkg::S_D_MUL: begin
                // zero time step: derivative stays zero, no divide to wait on
                w_mul_a = pidc_pkg::MUL_A_W'(r_gain_d);
                w_mul_b = r_deriv;
                if (r_dt == '0 || r_div_fin) begin
                    w_mul_start = 1'b1;
                    n_state     = pidc_pkg::S_D_WAIT;
                end
            end
            pidc_pkg::S_D_WAIT: begin
                if (w_mul_done) begin
                    n_state = pidc_pkg::S_OUT_CLAMP;
                end
            end
            pidc_pkg::S_OUT_CLAMP: begin
                if (w_out_free) begin
                    n_state = pidc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pidc_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // controller state and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ     <= '0;
            r_last_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept && s_axis_tuser) begin
                r_integ    <= '0;
                r_last_err <= '0;
            end
            if (r_state == pidc_pkg::S_INT_CLAMP) begin
                r_integ    <= clamp_sum(r_sum, r_int_lo, r_int_hi);
                r_last_err <= r_err;
            end
            if (r_state == pidc_pkg::S_OUT_CLAMP && w_out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // working registers (no reset needed)
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_target <= s_axis_tdata[DW-1:0];
            r_sample <= s_axis_tdata[2*DW-1:DW];
            r_dt     <= s_axis_tdata[3*DW-1:2*DW];
        end
        if (w_div_done) begin
            r_div_fin <= 1'b1;
            r_deriv   <= r_diff[pidc_pkg::DIFF_W-1] ? -$signed({1'b0, w_quo})
                                                    : $signed({1'b0, w_quo});
        end
        case (r_state)
            pidc_pkg::S_ERR: begin
                // last error is already cleared when clear_first was set
                r_err  <= pidc_pkg::ERR_W'(r_target) - pidc_pkg::ERR_W'(r_sample);
                r_diff <= pidc_pkg::DIFF_W'(pidc_pkg::ERR_W'(r_target)
                          - pidc_pkg::ERR_W'(r_sample))
                          - pidc_pkg::DIFF_W'(r_last_err);
            end
            pidc_pkg::S_INT_MUL: begin
                r_div_fin <= 1'b0;
                r_deriv   <= '0;
            end
            pidc_pkg::S_INT_WAIT: begin
                if (w_mul_done) begin
                    r_sum <= pidc_pkg::SUM_W'(r_integ) + pidc_pkg::SUM_W'(w_term);
                end
            end
            pidc_pkg::S_P_WAIT: begin
                if (w_mul_done) begin
                    r_sum <= pidc_pkg::SUM_W'(w_term);
                end
            end
            pidc_pkg::S_I_WAIT, pidc_pkg::S_D_WAIT: begin
                if (w_mul_done) begin
                    r_sum <= r_sum + pidc_pkg::SUM_W'(w_term);
                end
            end
            pidc_pkg::S_OUT_CLAMP: begin
                if (w_out_free) begin
                    r_out_data <= clamp_sum(r_sum, r_out_lo, r_out_hi);
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = pidc_pkg::OUT_W'(r_out_data);

    // ------------------------------------------------------------------
    // arithmetic units
    // ------------------------------------------------------------------
    pidc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_term  (w_term)
    );

    pidc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({w_diff_mag, {pidc_pkg::FRAC_W{1'b0}}}),
        .i_den   (r_dt),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

endmodule

`default_nettype wire

/* design/pidc_mul.sv */
// ----------------------------------------------------------------------------
// pidc_mul: shared sequenced fixed-point multiplier
// Sign-magnitude product, B in two chunks through one 32x32 multiplier,
// floor shift by FRAC_W and saturation to +-(2^61 - 1).
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_mul (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [pidc_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [pidc_pkg::MUL_B_W-1:0] i_b,
    output logic                                     o_done,
    output logic signed [pidc_pkg::TERM_W-1:0]       o_term
);

    localparam logic [pidc_pkg::ACC_W-1:0] RND =
        (pidc_pkg::ACC_W'(1) << pidc_pkg::FRAC_W) - pidc_pkg::ACC_W'(1);
    localparam logic [pidc_pkg::Q_W-1:0] TERM_MAX =
        (pidc_pkg::Q_W'(1) << (pidc_pkg::TERM_W - 1)) - pidc_pkg::Q_W'(1);

    logic                               r_busy;
    logic [1:0]                         r_ph;
    logic [pidc_pkg::DATA_W-1:0]        r_ma;
    logic [pidc_pkg::MUL_B_W-1:0]       r_mb;
    logic                               r_neg;
    logic [pidc_pkg::PROD_W-1:0]        r_prod;
    logic [pidc_pkg::ACC_W-1:0]         r_acc;
    logic                               r_done;
    logic signed [pidc_pkg::TERM_W-1:0] r_term;

    logic [pidc_pkg::MUL_A_W-1:0]  w_abs_a;
    logic [pidc_pkg::MUL_B_W-1:0]  w_abs_b;
    logic [pidc_pkg::MUL_CH_W-1:0] w_chunk;
    logic [pidc_pkg::Q_W-1:0]      w_q;
    logic [pidc_pkg::TERM_W-1:0]   w_mag;

    assign w_abs_a = i_a[pidc_pkg::MUL_A_W-1] ? -i_a : i_a;
    assign w_abs_b = i_b[pidc_pkg::MUL_B_W-1] ? -i_b : i_b;

    // low chunk first, then the high one
    assign w_chunk = (r_ph == 2'd0) ? r_mb[pidc_pkg::MUL_CH_W-1:0]
                   : pidc_pkg::MUL_CH_W'(r_mb[pidc_pkg::MUL_B_W-1:pidc_pkg::MUL_CH_W]);

    assign w_q   = r_acc[pidc_pkg::ACC_W-1:pidc_pkg::FRAC_W];
    assign w_mag = (w_q > TERM_MAX) ? pidc_pkg::TERM_W'(TERM_MAX)
                                    : pidc_pkg::TERM_W'(w_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= 2'd0;
            end else if (r_busy) begin
                r_ph <= r_ph + 2'd1;
                if (r_ph == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // |err| never reaches 2^32, so the magnitude fits DATA_W bits
            r_ma  <= w_abs_a[pidc_pkg::DATA_W-1:0];
            r_mb  <= w_abs_b;
            r_neg <= i_a[pidc_pkg::MUL_A_W-1] ^ i_b[pidc_pkg::MUL_B_W-1];
        end else if (r_busy) begin
            case (r_ph)
                2'd0: begin
                    r_prod <= r_ma * w_chunk;
                end
                2'd1: begin
                    // rounding bias on the magnitude gives a floor shift
                    r_acc  <= pidc_pkg::ACC_W'(r_prod)
                            + (r_neg ? RND : pidc_pkg::ACC_W'(0));
                    r_prod <= r_ma * w_chunk;
                end
                2'd2: begin
                    r_acc <= r_acc + (pidc_pkg::ACC_W'(r_prod) << pidc_pkg::MUL_CH_W);
                end
                default: begin
                    r_term <= r_neg ? -$signed(w_mag) : $signed(w_mag);
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_term = r_term;

endmodule

`default_nettype wire

/* design/pidc_div.sv */
// ----------------------------------------------------------------------------
// pidc_div: radix-2 restoring divider
// Unsigned quotient, one bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [pidc_pkg::DIV_NUM_W-1:0]    i_num,
    input  wire logic [pidc_pkg::DATA_W-1:0]       i_den,
    output logic                                   o_done,
    output logic [pidc_pkg::DIV_NUM_W-1:0]         o_quo
);

    logic [pidc_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_done;
    logic [pidc_pkg::DIV_NUM_W-1:0] r_quo;   // dividend shifts out, quotient in
    logic [pidc_pkg::DATA_W-1:0]    r_rem;
    logic [pidc_pkg::DATA_W-1:0]    r_den;

    logic [pidc_pkg::DATA_W:0] w_trial;
    logic                      w_fit;

    assign w_trial = {r_rem, r_quo[pidc_pkg::DIV_NUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= pidc_pkg::DIV_CNT_W'(pidc_pkg::DIV_NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - pidc_pkg::DIV_CNT_W'(1);
                if (r_cnt == pidc_pkg::DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= w_fit ? pidc_pkg::DATA_W'(w_trial - {1'b0, r_den})
                           : pidc_pkg::DATA_W'(w_trial);
            r_quo <= {r_quo[pidc_pkg::DIV_NUM_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

/* test/tb_pid_controller_clamped.sv */
// ----------------------------------------------------------------------------
// tb_pid_controller_clamped: self-checking bench for the clamped PID block
// Drives control update requests over the input stream and register writes
// over the config port, predicts every drive with a wide-integer model of the
// Q16.16 update and checks each output in order. A short directed script
// covers extremes, zero time step, state clear and odd limit settings; random
// phases with fresh gains and limits follow.
// ----------------------------------------------------------------------------

module tb_pid_controller_clamped;
    timeunit 1ns;
    timeprecision 1ps;

    import pidc_pkg::*;

    localparam int NUM_REGS    = int'(CFG_INTEG_UPPER) + 1;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;   // unmapped, write ignored

    localparam int IDLE_PCT    = 14;
    localparam int MAX_GAP     = 70;        // longest sender pause, cycles
    localparam int HOLD_AT     = 300;       // drives seen before the long hold-off
    localparam int HOLD_CYCLES = 600;
    localparam int CALM_TX_LO  = 400;       // sender never pauses in this window
    localparam int CALM_TX_HI  = 600;
    localparam int CALM_RX_LO  = 700;       // receiver never stalls in this window
    localparam int CALM_RX_HI  = 900;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 115;
    localparam int TAIL_CYCLES = 100;
    localparam int LIMIT_NS    = 15_000_000;

    // wide signed math: exact products of 64-bit operands fit
    typedef logic signed [127:0] wide_t;
    localparam wide_t TERM_LIM = 128'sh1FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic signed [DATA_W-1:0] target;
        logic signed [DATA_W-1:0] sample;
        logic        [DATA_W-1:0] step_time;
        logic                     clear_first;
    } update_t;

    typedef struct {
        int                  phase;
        logic [DATA_W-1:0]   target;
        logic [DATA_W-1:0]   sample;
        logic [DATA_W-1:0]   step_time;
        logic                clear_first;
        bit                  typed;       // drive below is the known answer
        logic [DATA_W-1:0]   drive;
    } script_row_t;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata  = '0;    // target, sample, step_time
    logic                  s_axis_tuser  = 1'b0;  // clear_first
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;          // drive
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [DATA_W-1:0]     i_cfg_data    = '0;

    pid_controller_clamped DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic signed [DATA_W-1:0] ctl_regs [NUM_REGS];   // predictor's register copy
    logic        [DATA_W-1:0] next_cfg [NUM_REGS];   // staged for the next write pass
    wide_t                    integ_state;
    wide_t                    err_state;

    logic [DATA_W-1:0]        pending_drives [$];
    logic [DATA_W-1:0]        got_drive;
    logic [DATA_W-1:0]        want_drive;
    int                       err_count   = 0;
    int                       items_sent  = 0;
    int                       drives_seen = 0;
    int unsigned              hold_left   = 0;
    bit                       held_once   = 1'b0;

    // Directed script. Phase 0 runs on reset values; each later phase loads
    // its own register set first (see the case in the main sequence).
    localparam int SCRIPT_LEN = 24;
    script_row_t script [SCRIPT_LEN] = '{
        // zero gains: drive is 0 whatever the error
        '{0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0000},
        '{0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
        '{0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1, 1'b1, 32'h0000_0000},
        // ordinary loop, integral runs into its upper limit
        '{1, 32'h000A_0000, 32'h0000_0000, 32'h0001_0000, 1'b1, 1'b0, '0},
        '{1, 32'h000A_0000, 32'h0004_8000, 32'h0000_8000, 1'b0, 1'b0, '0},
        '{1, 32'h000A_0000, 32'h0004_8000, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{1, 32'h0000_0000, 32'h0003_4000, 32'h0001_0000, 1'b0, 1'b0, '0},
        '{1, 32'h000A_0000, 32'h0000_0000, 32'h0010_0000, 1'b0, 1'b0, '0},
        '{1, 32'h000A_0000, 32'h0000_0000, 32'h0010_0000, 1'b0, 1'b0, '0},
        '{1, 32'h0000_0000, 32'h0000_0001, 32'h0000_0003, 1'b0, 1'b0, '0},
        '{1, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
        '{1, 32'h1234_5678, 32'h1234_5678, 32'h0001_0000, 1'b0, 1'b0, '0},
        // extreme gains: derivative term saturates
        '{2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1, 1'b0, '0},
        '{2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, '0},
        '{2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, '0},
        '{2, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{2, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0, '0},
        // lower limits above upper limits
        '{3, 32'h0005_0000, 32'h0000_0000, 32'h0001_0000, 1'b1, 1'b0, '0},
        '{3, 32'hFFF0_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 1'b0, '0},
        '{3, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
        // zero gains, lower 5.0 above upper -5.0: sum 0 lands on upper
        '{4, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0001_0000, 1'b0, 1'b1, 32'hFFFB_0000},
        '{4, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFB_0000},
        // both output limits 3.0: drive pinned there
        '{5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0, 1'b1, 32'h0003_0000},
        '{5, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h0003_0000}
    };

    // ------------------------------------------------------------------------
    // Drive predictor
    // ------------------------------------------------------------------------
    // (a*b) >> FRAC_W, floor rounding, saturated to +-(2^61 - 1)
    function automatic wide_t scaled_product(wide_t a, wide_t b);
        wide_t p;
        p = (a * b) >>> FRAC_W;
        if (p > TERM_LIM)
            p = TERM_LIM;
        else if (p < -TERM_LIM)
            p = -TERM_LIM;
        return p;
    endfunction

    // upper bound wins: with lo > hi anything not above hi ends up at lo
    function automatic wide_t clamp_to(wide_t v, wide_t lo, wide_t hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] predict_drive(update_t u);
        wide_t tgt, smp, err, step, integ, diff, mag, quot, deriv, sum;
        if (u.clear_first) begin
            integ_state = 0;
            err_state   = 0;
        end
        tgt  = u.target;
        smp  = u.sample;
        step = u.step_time;               // unsigned, zero-extended
        err  = tgt - smp;

        integ       = integ_state + scaled_product(err, step);
        integ_state = clamp_to(integ, ctl_regs[CFG_INTEG_LOWER], ctl_regs[CFG_INTEG_UPPER]);

        deriv = 0;
        if (step != 0) begin
            diff = err - err_state;
            mag  = (diff < 0) ? -diff : diff;
            if (mag > (TERM_LIM >>> FRAC_W))
                mag = TERM_LIM >>> FRAC_W;
            quot = (mag <<< FRAC_W) / step;   // truncates toward zero
            if (quot > TERM_LIM)
                quot = TERM_LIM;
            deriv = (diff < 0) ? -quot : quot;
        end

        sum = scaled_product(ctl_regs[CFG_GAIN_PROP], err)
            + scaled_product(ctl_regs[CFG_GAIN_INTEG], integ_state)
            + scaled_product(ctl_regs[CFG_GAIN_DERIV], deriv);
        sum = clamp_to(sum, ctl_regs[CFG_OUT_LOWER], ctl_regs[CFG_OUT_UPPER]);

        err_state = err;
        return sum[DATA_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            3, 4:    return $urandom();
            default: return DATA_W'($urandom_range(0, 32'h00C8_0000)) - 32'h0064_0000;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1:       return $urandom();
            2:       return '0;
            default: return DATA_W'($urandom_range(0, 32'h0006_0000)) - 32'h0003_0000;
        endcase
    endfunction

    function automatic void pick_limits(output logic [DATA_W-1:0] lo,
                                        output logic [DATA_W-1:0] hi);
        logic [DATA_W-1:0] a, b;
        a = pick_word();
        b = pick_word();
        case ($urandom_range(0, 5))
            0: begin
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
            end
            1: begin                     // either order, inverted bounds too
                lo = a;
                hi = b;
            end
            default: begin
                if ($signed(a) <= $signed(b)) begin
                    lo = a;
                    hi = b;
                end else begin
                    lo = b;
                    hi = a;
                end
            end
        endcase
    endfunction

    function automatic void set_cfg(logic [DATA_W-1:0] kp, logic [DATA_W-1:0] ki,
                                    logic [DATA_W-1:0] kd,
                                    logic [DATA_W-1:0] out_lo, logic [DATA_W-1:0] out_hi,
                                    logic [DATA_W-1:0] int_lo, logic [DATA_W-1:0] int_hi);
        next_cfg[CFG_GAIN_PROP]   = kp;
        next_cfg[CFG_GAIN_INTEG]  = ki;
        next_cfg[CFG_GAIN_DERIV]  = kd;
        next_cfg[CFG_OUT_LOWER]   = out_lo;
        next_cfg[CFG_OUT_UPPER]   = out_hi;
        next_cfg[CFG_INTEG_LOWER] = int_lo;
        next_cfg[CFG_INTEG_UPPER] = int_hi;
    endfunction

    // ------------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        err_count++;
        if (err_count <= 100)
            $display("%0t ns: %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // Writes all staged registers, sometimes also the unmapped index.
    // Only called with nothing in flight.
    task automatic write_config();
        for (int r = 0; r < NUM_REGS; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(r);
            i_cfg_data  <= next_cfg[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            ctl_regs[r] = next_cfg[r];
        end
        if ($urandom_range(0, 1)) begin
            i_cfg_index <= CFG_NO_REG;
            i_cfg_data  <= $urandom();
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Valid stays high between back-to-back requests; it only drops for a
    // pause or a drain, so it never gets two updates in one step.
    task automatic send_update(update_t u, bit typed, logic [DATA_W-1:0] typed_drive);
        logic [DATA_W-1:0] want;
        bit calm;
        calm = (items_sent >= CALM_TX_LO) && (items_sent < CALM_TX_HI);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {u.step_time, u.sample, u.target};
        s_axis_tuser  <= u.clear_first;
        do @(posedge i_clk); while (!s_axis_tready);
        want = predict_drive(u);
        pending_drives.push_back(typed ? typed_drive : want);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: check every accepted drive, stall at random, and once
    // hold off long enough that the block backs up into its input.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_drive = m_axis_tdata[DATA_W-1:0];
                if (pending_drives.size() == 0) begin
                    report_mismatch("drive with no request pending", got_drive, '0);
                end else begin
                    want_drive = pending_drives.pop_front();
                    if (got_drive !== want_drive)
                        report_mismatch("drive", got_drive, want_drive);
                end
                drives_seen++;
            end
            if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!held_once && drives_seen == HOLD_AT) begin
                held_once     <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (drives_seen >= CALM_RX_LO && drives_seen < CALM_RX_HI) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        update_t           u;
        int                cur_phase;
        logic [DATA_W-1:0] setpoint, out_lo, out_hi, int_lo, int_hi;

        // predictor starts from the reset register values
        ctl_regs[CFG_GAIN_PROP]   = '0;
        ctl_regs[CFG_GAIN_INTEG]  = '0;
        ctl_regs[CFG_GAIN_DERIV]  = '0;
        ctl_regs[CFG_OUT_LOWER]   = 32'h8000_0000;
        ctl_regs[CFG_OUT_UPPER]   = 32'h7FFF_FFFF;
        ctl_regs[CFG_INTEG_LOWER] = 32'h8000_0000;
        ctl_regs[CFG_INTEG_UPPER] = 32'h7FFF_FFFF;
        integ_state = 0;
        err_state   = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed script
        cur_phase = 0;
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            if (script[i].phase != cur_phase) begin
                cur_phase = script[i].phase;
                wait_drained();
                case (cur_phase)
                    1: set_cfg(32'h0001_0000, 32'h0000_8000, 32'h0000_4000,
                               32'hFF9C_0000, 32'h0064_0000, 32'hFFCE_0000, 32'h0032_0000);
                    2: set_cfg(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
                    3: set_cfg(32'h0002_0000, 32'hFFFF_0000, 32'h0000_2000,
                               32'h000A_0000, 32'hFFF6_0000, 32'h0005_0000, 32'hFFFB_0000);
                    4: set_cfg('0, '0, '0,
                               32'h0005_0000, 32'hFFFB_0000, 32'h8000_0000, 32'h7FFF_FFFF);
                    default: set_cfg(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                               32'h0003_0000, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF);
                endcase
                write_config();
            end
            u.target      = script[i].target;
            u.sample      = script[i].sample;
            u.step_time   = script[i].step_time;
            u.clear_first = script[i].clear_first;
            send_update(u, script[i].typed, script[i].drive);
        end

        // random phases: a closed loop around a setpoint that moves now and
        // then, with wild samples, odd time steps and clears mixed in
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            pick_limits(out_lo, out_hi);
            pick_limits(int_lo, int_hi);
            set_cfg(pick_gain(), pick_gain(), pick_gain(), out_lo, out_hi, int_lo, int_hi);
            write_config();
            setpoint = DATA_W'($urandom_range(0, 32'h0064_0000)) - 32'h0032_0000;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 19) == 0)
                    setpoint = pick_word();
                u.target = setpoint;
                if ($urandom_range(0, 9) == 0)
                    u.sample = pick_word();
                else
                    u.sample = setpoint + DATA_W'($urandom_range(0, 32'h0008_0000))
                             - 32'h0004_0000;
                case ($urandom_range(0, 19))
                    0:       u.step_time = '0;
                    1:       u.step_time = 32'h0000_0001;
                    2:       u.step_time = $urandom();
                    3:       u.step_time = 32'hFFFF_FFFF;
                    default: u.step_time = $urandom_range(32'h0000_0040, 32'h0002_0000);
                endcase
                u.clear_first = ($urandom_range(0, 24) == 0);
                send_update(u, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #(LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
design/pidc_pkg.sv
design/pidc_mul.sv
design/pidc_div.sv
design/pid_controller_clamped.sv
test/tb_pid_controller_clamped.sv
